FILE: src/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// Shared types and constants of the 3x3 stream filter: sample and coefficient
// widths, register map codes and the structs passed between the parts.
// ----------------------------------------------------------------------------
package cvf_pkg;

  // fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int RESULT_W    = 16;
  localparam int TAPS        = 3;
  localparam int ROW_COEF_W  = TAPS * COEF_W;
  localparam int DIM_W       = 13;
  localparam int SHIFT_W     = 5;
  localparam int PROD_W      = SAMPLE_W + COEF_W;

  // frame size minimum and reset value of the size registers
  localparam logic [DIM_W-1:0] DIM_MIN   = 13'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  // register port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LSB    = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_ADDR_W-CFG_LSB-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4,
    REG_RESULT_SHIFT = 3'd5
  } cfg_reg_t;

  // per-word classification made by the front
  typedef struct packed {
    logic emit;
    logic last;
  } cvf_tag_t;

  // kernel settings seen by the back
  typedef struct packed {
    logic [ROW_COEF_W-1:0] top;
    logic [ROW_COEF_W-1:0] mid;
    logic [ROW_COEF_W-1:0] bottom;
    logic [SHIFT_W-1:0]    shift;
  } cvf_kernel_t;

endpackage

FILE: src/cvf_queue.sv
// ----------------------------------------------------------------------------
// cvf_queue
// Small register FIFO that decouples the line-buffer front from the
// multiply-accumulate back.
// ----------------------------------------------------------------------------
module cvf_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full     = (count == CNTW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/cvf_front.sv
// ----------------------------------------------------------------------------
// cvf_front
// Takes input words, tracks the raster position, reads and updates the
// two-row line store and marks which words complete an interior window.
// ----------------------------------------------------------------------------
module cvf_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cvf_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                               frame_begin,
  input  logic [cvf_pkg::DIM_W-1:0]          width_eff,
  input  logic [cvf_pkg::DIM_W-1:0]          height_eff,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [cvf_pkg::SAMPLE_W-1:0]       q_sample,
  output logic [cvf_pkg::SAMPLE_W-1:0]       q_mid,
  output logic [cvf_pkg::SAMPLE_W-1:0]       q_top,
  output logic [$clog2(MAX_WIDTH)-1:0]       q_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]      q_row,
  output cvf_pkg::cvf_tag_t                  q_tag
);

  import cvf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int DW = (MW + 1 > DIM_W) ? MW + 1 : DIM_W;
  localparam int LW = 2 * SAMPLE_W;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic          accept;
  logic          col_wrap;
  cvf_tag_t      tag_cur;

  // line store: upper half is two rows up, lower half is one row up
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_word;

  // first stage registers
  logic                f1_valid;
  logic [SAMPLE_W-1:0] f1_sample;
  logic [CW-1:0]       f1_col;
  logic [RW-1:0]       f1_row;
  cvf_tag_t            f1_tag;
  logic                f1_byp;
  logic [LW-1:0]       f1_byp_word;
  logic [LW-1:0]       f1_word;
  logic                f1_go;
  logic [LW-1:0]       wr_word;

  assign in_stall = f1_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign f1_go    = f1_valid && !q_full;

  // position of the incoming word
  always_comb begin
    col_cur  = frame_begin ? '0 : col_count;
    row_cur  = frame_begin ? '0 : row_count;
    col_inc  = DW'(col_cur) + 1'b1;
    row_inc  = DW'(row_cur) + 1'b1;
    col_wrap = (col_inc >= DW'(width_eff));
    tag_cur.emit = (DW'(col_cur) >= DW'(2)) && (DW'(row_cur) >= DW'(2)) &&
                   (DW'(col_cur) < DW'(width_eff)) && (DW'(row_cur) < DW'(height_eff));
    tag_cur.last = (col_inc == DW'(width_eff)) && (row_inc == DW'(height_eff));
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= (row_inc >= DW'(height_eff)) ? '0 : row_inc[RW-1:0];
      end else begin
        col_count <= col_inc[CW-1:0];
        row_count <= row_cur;
      end
    end
  end

  // line store read and write-back of the shifted column
  assign f1_word = f1_byp ? f1_byp_word : rd_word;
  assign wr_word = {f1_word[SAMPLE_W-1:0], f1_sample};

  always_ff @(posedge clk) begin
    if (f1_go) begin
      line_mem[f1_col] <= wr_word;
    end
    if (accept) begin
      rd_word <= line_mem[col_cur];
    end
  end

  // first stage payload, with forwarding of a write to the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sample   <= sample_value;
      f1_col      <= col_cur;
      f1_row      <= row_cur;
      f1_tag      <= tag_cur;
      f1_byp      <= f1_go && (f1_col == col_cur);
      f1_byp_word <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (f1_go) begin
      f1_valid <= 1'b0;
    end
  end

  // hand the word with its column to the queue
  assign q_push   = f1_go;
  assign q_sample = f1_sample;
  assign q_mid    = f1_word[SAMPLE_W-1:0];
  assign q_top    = f1_word[LW-1:SAMPLE_W];
  assign q_col    = f1_col;
  assign q_row    = f1_row;
  assign q_tag    = f1_tag;

endmodule

FILE: src/cvf_back.sv
// ----------------------------------------------------------------------------
// cvf_back
// Shifts columns into the 3x3 window and runs the multiply, add, shift and
// saturate pipeline into the output register.
// ----------------------------------------------------------------------------
module cvf_back #(
  parameter int CW = 12,
  parameter int RW = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  output logic                               q_pop,
  input  logic [cvf_pkg::SAMPLE_W-1:0]       q_sample,
  input  logic [cvf_pkg::SAMPLE_W-1:0]       q_mid,
  input  logic [cvf_pkg::SAMPLE_W-1:0]       q_top,
  input  logic [CW-1:0]                      q_col,
  input  logic [RW-1:0]                      q_row,
  input  cvf_pkg::cvf_tag_t                  q_tag,
  input  cvf_pkg::cvf_kernel_t               kernel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cvf_pkg::RESULT_W-1:0] filtered_value,
  output logic [CW-1:0]                      center_col,
  output logic [RW-1:0]                      center_row,
  output logic                               frame_end
);

  import cvf_pkg::*;

  localparam int STAGES = 4;
  localparam int ROWS_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  logic adv;

  logic signed [SAMPLE_W-1:0] win   [TAPS][TAPS];
  logic signed [COEF_W-1:0]   coef  [TAPS][TAPS];
  logic signed [PROD_W-1:0]   prod  [TAPS][TAPS];
  logic signed [ROWS_W-1:0]   rsum  [TAPS];
  logic signed [SUM_W-1:0]    total;
  logic signed [SUM_W-1:0]    shifted;
  logic                       fits;

  // position and flags travelling beside the arithmetic
  logic          pv   [STAGES];
  logic [CW-1:0] pcol [STAGES];
  logic [RW-1:0] prow [STAGES];
  logic          plast[STAGES];

  // whole pipeline moves unless a finished result is held
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // coefficients, left tap in low bits
  always_comb begin
    for (int c = 0; c < TAPS; c++) begin
      coef[0][c] = kernel.top[c*COEF_W +: COEF_W];
      coef[1][c] = kernel.mid[c*COEF_W +: COEF_W];
      coef[2][c] = kernel.bottom[c*COEF_W +: COEF_W];
    end
  end

  // window shift on each word taken from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      win[0][TAPS-1] <= q_top;
      win[1][TAPS-1] <= q_mid;
      win[2][TAPS-1] <= q_sample;
    end
  end

  // products, row sums, total
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          prod[r][c] <= win[r][c] * coef[r][c];
        end
        rsum[r] <= ROWS_W'(prod[r][0]) + ROWS_W'(prod[r][1]) + ROWS_W'(prod[r][2]);
      end
      total <= SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
    end
  end

  // side-band pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      pcol[0]  <= q_col;
      prow[0]  <= q_row;
      plast[0] <= q_tag.last;
      for (int s = 1; s < STAGES; s++) begin
        pcol[s]  <= pcol[s-1];
        prow[s]  <= prow[s-1];
        plast[s] <= plast[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        pv[s] <= 1'b0;
      end
    end else if (adv) begin
      pv[0] <= q_pop && q_tag.emit;
      for (int s = 1; s < STAGES; s++) begin
        pv[s] <= pv[s-1];
      end
    end
  end

  // shift and saturate
  always_comb begin
    shifted = total >>> kernel.shift;
    fits    = (shifted[SUM_W-1:RESULT_W-1] == '0) || (shifted[SUM_W-1:RESULT_W-1] == '1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (fits) begin
        filtered_value <= shifted[RESULT_W-1:0];
      end else begin
        filtered_value <= {shifted[SUM_W-1], {(RESULT_W-1){!shifted[SUM_W-1]}}};
      end
      center_col <= pcol[STAGES-1] - 1'b1;
      center_row <= prow[STAGES-1] - 1'b1;
      frame_end  <= plast[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pv[STAGES-1];
    end
  end

endmodule

FILE: src/conv3x3_stream_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_stream_filter_core
// 3x3 convolution over a raster sample stream, with register port.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one signed sample per word in
// raster order; frame_begin marks pixel (0,0). Output channel: out_valid /
// out_stall carry one filtered word per interior pixel with its center
// column and row; frame_end marks the last result of a frame.
// Throughput: one word per cycle on both sides while out_stall is low.
// The line store is one memory with a read and a write port; a column is
// read when its word is taken and written back as that word moves on to
// the queue. The word that completes a window passes through registers
// for line read, queue, window, products, row sums, total and output.
// A stalled output holds the back pipeline; the four-word queue then fills
// and in_stall rises as soon as it is full with a word waiting in the front.
// Reset clears counters, pipeline valids and registers; the line store has
// no clearing pass, its stale contents never reach a result.
// Registers at 8*i: width, height, three coefficient rows, result shift.
// ----------------------------------------------------------------------------
module conv3x3_stream_filter_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cvf_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                                 frame_begin,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cvf_pkg::RESULT_W-1:0]  filtered_value,
  output logic [$clog2(MAX_WIDTH)-1:0]         center_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]        center_row,
  output logic                                 frame_end,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cvf_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cvf_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cvf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import cvf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = 3 * SAMPLE_W + CW + RW + $bits(cvf_tag_t);

  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic [ROW_COEF_W-1:0] coef_top_row;
  logic [ROW_COEF_W-1:0] coef_mid_row;
  logic [ROW_COEF_W-1:0] coef_bottom_row;
  logic [SHIFT_W-1:0]    result_shift;
  logic [DIM_W-1:0]      width_eff;
  logic [DIM_W-1:0]      height_eff;
  logic                  cfg_wr;
  cfg_reg_t              cfg_sel;
  cvf_kernel_t           kernel;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [QW-1:0]       q_in;
  logic [QW-1:0]       q_out;
  logic [SAMPLE_W-1:0] fq_sample;
  logic [SAMPLE_W-1:0] fq_mid;
  logic [SAMPLE_W-1:0] fq_top;
  logic [CW-1:0]       fq_col;
  logic [RW-1:0]       fq_row;
  cvf_tag_t            fq_tag;
  logic [SAMPLE_W-1:0] bq_sample;
  logic [SAMPLE_W-1:0] bq_mid;
  logic [SAMPLE_W-1:0] bq_top;
  logic [CW-1:0]       bq_col;
  logic [RW-1:0]       bq_row;
  cvf_tag_t            bq_tag;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= DIM_RESET;
      frame_height    <= DIM_RESET;
      coef_top_row    <= '0;
      coef_mid_row    <= '0;
      coef_bottom_row <= '0;
      result_shift    <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width     <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height    <= pwdata[DIM_W-1:0];
        REG_COEF_TOP:     coef_top_row    <= pwdata[ROW_COEF_W-1:0];
        REG_COEF_MID:     coef_mid_row    <= pwdata[ROW_COEF_W-1:0];
        REG_COEF_BOTTOM:  coef_bottom_row <= pwdata[ROW_COEF_W-1:0];
        REG_RESULT_SHIFT: result_shift    <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      REG_COEF_TOP:     prdata = CFG_DATA_W'(coef_top_row);
      REG_COEF_MID:     prdata = CFG_DATA_W'(coef_mid_row);
      REG_COEF_BOTTOM:  prdata = CFG_DATA_W'(coef_bottom_row);
      REG_RESULT_SHIFT: prdata = CFG_DATA_W'(result_shift);
      default:          prdata = '0;
    endcase
  end

  // frame size limited to the supported range
  always_comb begin
    if (frame_width < DIM_MIN) begin
      width_eff = DIM_MIN;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height < DIM_MIN) begin
      height_eff = DIM_MIN;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  assign kernel.top    = coef_top_row;
  assign kernel.mid    = coef_mid_row;
  assign kernel.bottom = coef_bottom_row;
  assign kernel.shift  = result_shift;

  // front: position tracking and line store
  cvf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .frame_begin  (frame_begin),
    .width_eff    (width_eff),
    .height_eff   (height_eff),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_sample     (fq_sample),
    .q_mid        (fq_mid),
    .q_top        (fq_top),
    .q_col        (fq_col),
    .q_row        (fq_row),
    .q_tag        (fq_tag)
  );

  // queue between the two halves
  assign q_in = {fq_sample, fq_mid, fq_top, fq_col, fq_row, fq_tag};
  assign {bq_sample, bq_mid, bq_top, bq_col, bq_row, bq_tag} = q_out;

  cvf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // back: window and arithmetic
  cvf_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_sample       (bq_sample),
    .q_mid          (bq_mid),
    .q_top          (bq_top),
    .q_col          (bq_col),
    .q_row          (bq_row),
    .q_tag          (bq_tag),
    .kernel         (kernel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .center_col     (center_col),
    .center_row     (center_row),
    .frame_end      (frame_end)
  );

`ifndef SYNTH
  // results are always interior pixels
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_col != '0) && (center_row != '0))
    else $error("result at a border pixel");

  // the frame's last result sits at the last interior pixel
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |->
      (DIM_W'(center_col) == width_eff - DIM_W'(2)) &&
      (DIM_W'(center_row) == height_eff - DIM_W'(2)))
    else $error("frame end on a wrong pixel");

  // nothing comes out in the cycle after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");
`endif

endmodule
